### design/ppmb_pkg.sv
// Package for the ping-pong message mailbox: field widths, status and opcode codes,
// controller state encoding, and the command and status bundles between the controller
// and the datapath. No dependencies.
`default_nettype none

package ppmb_pkg;

   // Fixed field widths of the transaction payloads.
   localparam int OBJ_IDX_W = 4;
   localparam int LEN_W     = 8;
   localparam int BYTE_W    = 8;
   localparam int STATUS_W  = 2;
   localparam int OUT_LEN_W = 7;

   // Every stored message is preceded by a four-byte length tag.
   localparam int TAG_BYTES = 4;

   typedef enum logic [STATUS_W-1:0] {
      ST_INS_OK   = 2'd0,
      ST_INS_REJ  = 2'd1,
      ST_MSG_BYTE = 2'd2,
      ST_NO_MSG   = 2'd3
   } status_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_GET    = 1'b1
   } opcode_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_READ,
      S_INS_CHECK,
      S_INS_BYTE,
      S_INS_DONE,
      S_GET_READ,
      S_GET_CHECK,
      S_GET_TAG,
      S_GET_LEN,
      S_GET_DATA,
      S_GET_EMPTY
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_item;
      logic       clear_insert;
      logic       latch_insert;
      logic       tbl_rd;
      logic       tag_wr;
      logic       data_wr;
      logic       seen_inc;
      logic       tbl_wr_insert;
      logic       swap_load;
      logic       mem_rd_tag;
      logic       mem_rd_data;
      logic       len_load;
      logic       idx_inc;
      logic       tbl_wr_drain;
      logic       tbl_wr_rec;
      logic       push;
      status_type push_code;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_get;
      logic seen_zero;
      logic ins_last;
      logic rejected;
      logic obj_ok;
      logic drain_empty;
      logic n_zero;
      logic msg_last;
      logic out_free;
   } ctrl_stat_type;

endpackage

`default_nettype wire

### design/ppmb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module ppmb_ram #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 4,
   parameter int DEPTH  = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/ppmb_ctrl.sv
// Controller state machine of the ping-pong message mailbox.
// Depends on ppmb_pkg for the state encoding and the command and status bundles.
`default_nettype none

module ppmb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ppmb_pkg::ctrl_stat_type stat,
   output ppmb_pkg::ctrl_cmd_type  cmd
);

   import ppmb_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.push_code = ST_INS_OK;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               if (stat.req_get) begin
                  state_in = S_GET_READ;
               end else if (stat.seen_zero) begin
                  state_in = S_INS_READ;
               end else begin
                  state_in = S_INS_BYTE;
               end
            end
         end
         S_INS_READ: begin
            cmd.tbl_rd = 1'b1;
            state_in   = S_INS_CHECK;
         end
         S_INS_CHECK: begin
            cmd.latch_insert = 1'b1;
            cmd.tag_wr       = 1'b1;
            state_in         = S_INS_BYTE;
         end
         S_INS_BYTE: begin
            cmd.data_wr  = 1'b1;
            cmd.seen_inc = 1'b1;
            if (stat.ins_last) begin
               state_in = S_INS_DONE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_INS_DONE: begin
            if (stat.out_free) begin
               cmd.push          = 1'b1;
               cmd.push_code     = stat.rejected ? ST_INS_REJ : ST_INS_OK;
               cmd.tbl_wr_insert = 1'b1;
               cmd.clear_insert  = 1'b1;
               state_in          = S_IDLE;
            end
         end
         S_GET_READ: begin
            // A get drops any partial insert.
            cmd.clear_insert = 1'b1;
            cmd.tbl_rd       = 1'b1;
            if (stat.obj_ok) begin
               state_in = S_GET_CHECK;
            end else begin
               state_in = S_GET_EMPTY;
            end
         end
         S_GET_CHECK: begin
            cmd.swap_load = 1'b1;
            if (stat.drain_empty) begin
               state_in = S_GET_EMPTY;
            end else begin
               state_in = S_GET_TAG;
            end
         end
         S_GET_TAG: begin
            cmd.mem_rd_tag = 1'b1;
            state_in       = S_GET_LEN;
         end
         S_GET_LEN: begin
            cmd.len_load = 1'b1;
            if (stat.n_zero) begin
               state_in = S_GET_EMPTY;
            end else begin
               cmd.mem_rd_data = 1'b1;
               state_in        = S_GET_DATA;
            end
         end
         S_GET_DATA: begin
            if (stat.out_free) begin
               cmd.push      = 1'b1;
               cmd.push_code = ST_MSG_BYTE;
               if (stat.msg_last) begin
                  cmd.tbl_wr_drain = 1'b1;
                  state_in         = S_IDLE;
               end else begin
                  cmd.idx_inc     = 1'b1;
                  cmd.mem_rd_data = 1'b1;
               end
            end
         end
         S_GET_EMPTY: begin
            if (stat.out_free) begin
               cmd.push       = 1'b1;
               cmd.push_code  = ST_NO_MSG;
               cmd.tbl_wr_rec = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### design/ppmb_dp.sv
// Datapath of the ping-pong message mailbox: item and insert registers, the per-object
// table with valid bits, the message store, and the result register.
// Depends on ppmb_pkg and ppmb_ram.
`default_nettype none

module ppmb_dp #(
   parameter int NUM_OBJECTS = 16,
   parameter int BANK_BYTES  = 4096,
   parameter int MAX_MESSAGE = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ppmb_pkg::ctrl_cmd_type            cmd,
   output ppmb_pkg::ctrl_stat_type           stat,
   input  logic                              req_opcode,
   input  logic [ppmb_pkg::OBJ_IDX_W-1:0]    req_object_index,
   input  logic [ppmb_pkg::LEN_W-1:0]        req_message_length,
   input  logic [ppmb_pkg::BYTE_W-1:0]       req_data_byte,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [ppmb_pkg::STATUS_W-1:0]     rsp_status,
   output logic [ppmb_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic [ppmb_pkg::OUT_LEN_W-1:0]    rsp_out_length,
   output logic                              rsp_last_of_run
);

   import ppmb_pkg::*;

   localparam int OBJ_W     = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
   localparam int PW        = $clog2(BANK_BYTES);
   localparam int FILL_W    = $clog2(BANK_BYTES + 1);
   localparam int CNT_W     = $clog2(BANK_BYTES / (TAG_BYTES + 1) + 1);
   localparam int SUM_W     = FILL_W + 4;
   localparam int REC_W     = 1 + 2 * FILL_W + 2 * CNT_W;
   localparam int MEM_AW    = OBJ_W + 1 + PW;
   localparam int MEM_DEPTH = NUM_OBJECTS * (2 ** (PW + 1));
   localparam int IDX_W     = OUT_LEN_W;

   // Latched transaction fields.
   logic [OBJ_IDX_W-1:0] item_obj_ff;
   logic [LEN_W-1:0]     item_len_ff;
   logic [BYTE_W-1:0]    item_data_ff;

   // Insert progress.
   logic [OBJ_IDX_W-1:0] ins_obj_ff;
   logic [LEN_W-1:0]     ins_len_ff;
   logic [LEN_W-1:0]     seen_ff;
   logic [LEN_W-1:0]     seen_in;
   logic                 rej_ff;
   logic                 rej_in;

   // Working copy of one object's record.
   logic              rec_bank_ff;
   logic [FILL_W-1:0] rec_fill_ff;
   logic [CNT_W-1:0]  rec_live_ff;
   logic [CNT_W-1:0]  rec_dcnt_ff;
   logic [FILL_W-1:0] rec_dpos_ff;

   // Drain progress.
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic [IDX_W-1:0] n_ff;
   logic [IDX_W-1:0] n_calc;

   // Object table and its valid bits.
   logic [NUM_OBJECTS-1:0] tbl_vld_ff;
   logic                   tbl_vld_rd_ff;
   logic                   tbl_re;
   logic                   tbl_we;
   logic [OBJ_W-1:0]       tbl_wr_addr;
   logic [REC_W-1:0]       tbl_wr_data;
   logic [REC_W-1:0]       tbl_rd_data;

   logic              r_bank;
   logic [FILL_W-1:0] r_fill;
   logic [CNT_W-1:0]  r_live;
   logic [CNT_W-1:0]  r_dcnt;
   logic [FILL_W-1:0] r_dpos;

   logic              t_bank;
   logic [FILL_W-1:0] t_fill;
   logic [CNT_W-1:0]  t_live;
   logic [CNT_W-1:0]  t_dcnt;
   logic [FILL_W-1:0] t_dpos;

   logic              s_bank;
   logic [FILL_W-1:0] s_fill;
   logic [CNT_W-1:0]  s_live;
   logic [CNT_W-1:0]  s_dcnt;
   logic [FILL_W-1:0] s_dpos;

   // Message store ports.
   logic              mem_we;
   logic [MEM_AW-1:0] mem_wr_addr;
   logic [BYTE_W-1:0] mem_wr_data;
   logic              mem_re;
   logic [MEM_AW-1:0] mem_rd_addr;
   logic [BYTE_W-1:0] mem_rd_data;

   logic [OBJ_W-1:0]  item_obj_a;
   logic [OBJ_W-1:0]  ins_obj_a;
   logic              obj_ok;
   logic              reject;
   logic [SUM_W-1:0]  need_sum;
   logic [SUM_W-1:0]  data_pos;
   logic [SUM_W-1:0]  rd_pos;
   logic [SUM_W-1:0]  dpos_sum;
   logic [FILL_W-1:0] dpos_next;
   logic              msg_last;

   // Result register.
   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic [IDX_W-1:0]  rsp_len_ff;
   logic              rsp_last_ff;
   logic              out_free;

   assign item_obj_a = OBJ_W'(item_obj_ff);
   assign ins_obj_a  = OBJ_W'(ins_obj_ff);
   assign obj_ok     = int'(item_obj_ff) < NUM_OBJECTS;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // Table read data; an entry never written reads as all zero.
   assign {r_bank, r_fill, r_live, r_dcnt, r_dpos} = tbl_rd_data;
   assign t_bank = tbl_vld_rd_ff ? r_bank : 1'b0;
   assign t_fill = tbl_vld_rd_ff ? r_fill : '0;
   assign t_live = tbl_vld_rd_ff ? r_live : '0;
   assign t_dcnt = tbl_vld_rd_ff ? r_dcnt : '0;
   assign t_dpos = tbl_vld_rd_ff ? r_dpos : '0;

   // Bank swap when the drain bank has no message left.
   always_comb begin
      if (t_dcnt == '0) begin
         s_bank = ~t_bank;
         s_fill = '0;
         s_live = '0;
         s_dcnt = t_live;
         s_dpos = '0;
      end else begin
         s_bank = t_bank;
         s_fill = t_fill;
         s_live = t_live;
         s_dcnt = t_dcnt;
         s_dpos = t_dpos;
      end
   end

   // Acceptance check on a message's first byte.
   assign need_sum = SUM_W'(t_fill) + SUM_W'(TAG_BYTES) + SUM_W'(item_len_ff);
   assign reject   = !obj_ok || (item_len_ff == '0)
                     || (item_len_ff > LEN_W'(MAX_MESSAGE))
                     || (need_sum > SUM_W'(BANK_BYTES));

   // Message store write: the tag on the first byte, data on every byte.
   assign data_pos    = SUM_W'(rec_fill_ff) + SUM_W'(TAG_BYTES) + SUM_W'(seen_ff);
   assign mem_we      = (cmd.tag_wr && !reject) || (cmd.data_wr && !rej_ff);
   assign mem_wr_addr = cmd.tag_wr ? {item_obj_a, t_bank, t_fill[PW-1:0]}
                                   : {ins_obj_a, rec_bank_ff, data_pos[PW-1:0]};
   assign mem_wr_data = cmd.tag_wr ? item_len_ff : item_data_ff;

   // Message store read from the drain bank: tag first, then data bytes.
   always_comb begin
      if (cmd.mem_rd_tag) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end else begin
         idx_in = idx_ff;
      end
   end
   assign rd_pos      = cmd.mem_rd_tag ? SUM_W'(rec_dpos_ff)
                        : SUM_W'(rec_dpos_ff) + SUM_W'(TAG_BYTES) + SUM_W'(idx_in);
   assign mem_re      = cmd.mem_rd_tag || cmd.mem_rd_data;
   assign mem_rd_addr = {item_obj_a, ~rec_bank_ff, rd_pos[PW-1:0]};

   // Message length from the tag, clamped to the largest message.
   assign n_calc   = (mem_rd_data > BYTE_W'(MAX_MESSAGE)) ? IDX_W'(MAX_MESSAGE)
                                                         : IDX_W'(mem_rd_data);
   assign msg_last = (idx_ff + IDX_W'(1)) == n_ff;

   // Drain position after the message, wrapped at the bank size.
   assign dpos_sum  = SUM_W'(rec_dpos_ff) + SUM_W'(TAG_BYTES) + SUM_W'(n_ff);
   assign dpos_next = (dpos_sum >= SUM_W'(BANK_BYTES))
                      ? FILL_W'(dpos_sum - SUM_W'(BANK_BYTES)) : FILL_W'(dpos_sum);

   // Object table write-back.
   assign tbl_re      = cmd.tbl_rd && obj_ok;
   assign tbl_we      = (cmd.tbl_wr_insert && !rej_ff) || cmd.tbl_wr_drain
                        || (cmd.tbl_wr_rec && obj_ok);
   assign tbl_wr_addr = cmd.tbl_wr_insert ? ins_obj_a : item_obj_a;
   always_comb begin
      if (cmd.tbl_wr_insert) begin
         tbl_wr_data = {rec_bank_ff,
                        FILL_W'(SUM_W'(rec_fill_ff) + SUM_W'(TAG_BYTES) + SUM_W'(ins_len_ff)),
                        rec_live_ff + CNT_W'(1), rec_dcnt_ff, rec_dpos_ff};
      end else if (cmd.tbl_wr_drain) begin
         tbl_wr_data = {rec_bank_ff, rec_fill_ff, rec_live_ff,
                        rec_dcnt_ff - CNT_W'(1), dpos_next};
      end else begin
         tbl_wr_data = {rec_bank_ff, rec_fill_ff, rec_live_ff, rec_dcnt_ff, rec_dpos_ff};
      end
   end

   // Insert counters.
   always_comb begin
      seen_in = seen_ff;
      rej_in  = rej_ff;
      if (cmd.clear_insert) begin
         seen_in = '0;
         rej_in  = 1'b0;
      end else begin
         if (cmd.latch_insert) begin
            rej_in = reject;
         end
         if (cmd.seen_inc) begin
            seen_in = seen_ff + LEN_W'(1);
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= '0;
         rej_ff       <= 1'b0;
         tbl_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
         rej_ff  <= rej_in;
         if (tbl_we) begin
            tbl_vld_ff[tbl_wr_addr] <= 1'b1;
         end
         if (cmd.push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_obj_ff  <= req_object_index;
         item_len_ff  <= req_message_length;
         item_data_ff <= req_data_byte;
      end
      if (cmd.latch_insert) begin
         ins_obj_ff <= item_obj_ff;
         ins_len_ff <= item_len_ff;
      end
      if (tbl_re) begin
         tbl_vld_rd_ff <= tbl_vld_ff[item_obj_a];
      end
      if (cmd.latch_insert) begin
         rec_bank_ff <= t_bank;
         rec_fill_ff <= t_fill;
         rec_live_ff <= t_live;
         rec_dcnt_ff <= t_dcnt;
         rec_dpos_ff <= t_dpos;
      end else if (cmd.swap_load) begin
         rec_bank_ff <= s_bank;
         rec_fill_ff <= s_fill;
         rec_live_ff <= s_live;
         rec_dcnt_ff <= s_dcnt;
         rec_dpos_ff <= s_dpos;
      end
      idx_ff <= idx_in;
      if (cmd.len_load) begin
         n_ff <= n_calc;
      end
      if (cmd.push) begin
         rsp_status_ff <= cmd.push_code;
         if (cmd.push_code == ST_MSG_BYTE) begin
            rsp_byte_ff <= mem_rd_data;
            rsp_len_ff  <= n_ff;
            rsp_last_ff <= msg_last;
         end else begin
            rsp_byte_ff <= '0;
            rsp_len_ff  <= '0;
            rsp_last_ff <= 1'b1;
         end
      end
   end

   // Status to the controller.
   assign stat.req_get     = req_opcode == OP_GET;
   assign stat.seen_zero   = seen_ff == '0;
   assign stat.ins_last    = (ins_len_ff == '0)
                             || ((LEN_W + 1)'(seen_ff) + (LEN_W + 1)'(1)
                                 >= (LEN_W + 1)'(ins_len_ff));
   assign stat.rejected    = rej_ff;
   assign stat.obj_ok      = obj_ok;
   assign stat.drain_empty = s_dcnt == '0;
   assign stat.n_zero      = mem_rd_data == '0;
   assign stat.msg_last    = msg_last;
   assign stat.out_free    = out_free;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_out_length  = rsp_len_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // Per-object records.
   ppmb_ram #(
      .DATA_W (REC_W),
      .ADDR_W (OBJ_W),
      .DEPTH  (NUM_OBJECTS)
   ) u_obj_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_re),
      .rd_addr (item_obj_a),
      .rd_data (tbl_rd_data)
   );

   // Message bytes, two banks per object.
   ppmb_ram #(
      .DATA_W (BYTE_W),
      .ADDR_W (MEM_AW),
      .DEPTH  (MEM_DEPTH)
   ) u_msg_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_re),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

### design/ping_pong_message_mailbox_top.sv
// Ping-pong message mailbox. An insert byte that continues a message passes the byte state
// only, the first byte of a message also the table read and check states, and the last byte
// also a done state that posts its status. A get reads the object table, checks it, reads
// the tag, then gives one byte per cycle while the receiver takes them; the object table and
// the message store have registered reads. Reset clears the controller, the insert counters,
// the result valid flag and the object valid bits; the message store is not cleared.
`default_nettype none

module ping_pong_message_mailbox_top #(
   parameter int NUM_OBJECTS = 16,
   parameter int BANK_BYTES  = 4096,
   parameter int MAX_MESSAGE = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_opcode,
   input  logic [ppmb_pkg::OBJ_IDX_W-1:0]    req_object_index,
   input  logic [ppmb_pkg::LEN_W-1:0]        req_message_length,
   input  logic [ppmb_pkg::BYTE_W-1:0]       req_data_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ppmb_pkg::STATUS_W-1:0]     rsp_status,
   output logic [ppmb_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic [ppmb_pkg::OUT_LEN_W-1:0]    rsp_out_length,
   output logic                              rsp_last_of_run
);

   import ppmb_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   // Controller.
   ppmb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath with the object table and message store.
   ppmb_dp #(
      .NUM_OBJECTS (NUM_OBJECTS),
      .BANK_BYTES  (BANK_BYTES),
      .MAX_MESSAGE (MAX_MESSAGE)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_opcode         (req_opcode),
      .req_object_index   (req_object_index),
      .req_message_length (req_message_length),
      .req_data_byte      (req_data_byte),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_out_length     (rsp_out_length),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule

`default_nettype wire

### test/tb_ping_pong_message_mailbox_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for ping_pong_message_mailbox_top: a directed table, random insert
// and get transactions and a length-limit test, scored against a behavioral mailbox predictor
// or a typed-in status. Depends on ppmb_pkg and the mailbox RTL only.

module tb_ping_pong_message_mailbox_top;
   import ppmb_pkg::*;

   localparam int NUM_OBJ        = 16;
   localparam int BANK           = 4096;
   localparam int MAX_MSG        = 64;
   localparam int CLK_HIGH       = 6;
   localparam int CLK_LOW        = 6;
   localparam int RESET_CYCLES   = 5;
   localparam int TAIL_CYCLES    = 20;
   localparam int TIMEOUT_CYCLES = 1500000;
   localparam int RANDOM_ITEMS   = 260;
   localparam int N_DIRECTED     = 25;
   localparam int LIMIT_OBJ      = 14;

   // One result transaction as the mailbox presents it.
   typedef struct packed {
      status_type             status;
      logic [BYTE_W-1:0]      out_byte;
      logic [OUT_LEN_W-1:0]   out_length;
      logic                   last_of_run;
   } mbox_result_type;

   // One directed request; fixed rows carry a typed-in single status result.
   typedef struct packed {
      opcode_type             op;
      logic [OBJ_IDX_W-1:0]   obj;
      logic [LEN_W-1:0]       len;
      logic [BYTE_W-1:0]      data;
      logic                   fixed;
      status_type             fixed_status;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_opcode = 1'b0;
   logic [OBJ_IDX_W-1:0]   req_object_index = '0;
   logic [LEN_W-1:0]       req_message_length = '0;
   logic [BYTE_W-1:0]      req_data_byte = '0;
   logic                   rsp_ready = 1'b0;
   wire logic              req_ready;
   wire logic              rsp_valid;
   wire logic [STATUS_W-1:0]  rsp_status;
   wire logic [BYTE_W-1:0]    rsp_out_byte;
   wire logic [OUT_LEN_W-1:0] rsp_out_length;
   wire logic                 rsp_last_of_run;

   ping_pong_message_mailbox_top #(
      .NUM_OBJECTS (NUM_OBJ),
      .BANK_BYTES  (BANK),
      .MAX_MESSAGE (MAX_MSG)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_object_index   (req_object_index),
      .req_message_length (req_message_length),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_out_length     (rsp_out_length),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   always begin
      #CLK_HIGH clock = 1'b1;
      #CLK_LOW  clock = 1'b0;
   end

   // Mirror of the mailbox state kept by the predictor.
   logic [7:0]  store_bytes [NUM_OBJ*2*BANK];
   logic        live_bank   [NUM_OBJ];
   logic [12:0] live_fill   [NUM_OBJ];
   logic [9:0]  live_count  [NUM_OBJ];
   logic [9:0]  drain_count [NUM_OBJ];
   logic [12:0] drain_pos   [NUM_OBJ];
   logic [7:0]  ins_seen     = '0;
   logic        ins_rejected = 1'b0;
   logic [3:0]  ins_obj      = '0;
   logic [7:0]  ins_len      = '0;

   mbox_result_type step_results [$];
   mbox_result_type results_due  [$];

   int mismatch_count = 0;
   int items_sent     = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;

   stim_row_type directed_rows [N_DIRECTED] = '{
      '{OP_GET,    4'd0,  8'd0,   8'h00, 1'b1, ST_NO_MSG},
      '{OP_INSERT, 4'd1,  8'd0,   8'hFF, 1'b1, ST_INS_REJ},
      '{OP_INSERT, 4'd2,  8'd1,   8'h00, 1'b1, ST_INS_OK},
      '{OP_INSERT, 4'd2,  8'd1,   8'hFF, 1'b1, ST_INS_OK},
      '{OP_GET,    4'd2,  8'd0,   8'h00, 1'b0, ST_INS_OK},
      '{OP_GET,    4'd2,  8'd0,   8'h00, 1'b0, ST_INS_OK},
      '{OP_GET,    4'd2,  8'd0,   8'h00, 1'b1, ST_NO_MSG},
      // Later bytes of a message carry other object and length values.
      '{OP_INSERT, 4'd15, 8'd3,   8'hA5, 1'b0, ST_INS_OK},
      '{OP_INSERT, 4'd4,  8'd9,   8'h5A, 1'b0, ST_INS_OK},
      '{OP_INSERT, 4'd0,  8'd0,   8'h3C, 1'b0, ST_INS_OK},
      '{OP_GET,    4'd15, 8'd0,   8'h00, 1'b0, ST_INS_OK},
      // An over-long message cut short by a get is dropped silently.
      '{OP_INSERT, 4'd5,  8'd255, 8'h12, 1'b0, ST_INS_OK},
      '{OP_GET,    4'd5,  8'd0,   8'h00, 1'b1, ST_NO_MSG},
      // Inserts while the drain bank still holds messages, then bank swaps.
      '{OP_INSERT, 4'd9,  8'd1,   8'h11, 1'b1, ST_INS_OK},
      '{OP_INSERT, 4'd9,  8'd1,   8'h22, 1'b1, ST_INS_OK},
      '{OP_INSERT, 4'd9,  8'd1,   8'h33, 1'b1, ST_INS_OK},
      '{OP_GET,    4'd9,  8'd0,   8'h00, 1'b0, ST_INS_OK},
      '{OP_INSERT, 4'd9,  8'd2,   8'h44, 1'b0, ST_INS_OK},
      '{OP_INSERT, 4'd9,  8'd2,   8'h55, 1'b0, ST_INS_OK},
      '{OP_GET,    4'd9,  8'd0,   8'h00, 1'b0, ST_INS_OK},
      '{OP_GET,    4'd9,  8'd0,   8'h00, 1'b0, ST_INS_OK},
      '{OP_GET,    4'd9,  8'd0,   8'h00, 1'b0, ST_INS_OK},
      '{OP_GET,    4'd9,  8'd0,   8'h00, 1'b1, ST_NO_MSG},
      // A valid partial message dropped by a get on an empty object.
      '{OP_INSERT, 4'd6,  8'd2,   8'h80, 1'b0, ST_INS_OK},
      '{OP_GET,    4'd6,  8'd0,   8'h00, 1'b1, ST_NO_MSG}
   };

   function automatic int store_addr(int obj, int bank, int pos);
      return (obj * 2 + bank) * BANK + (pos % BANK);
   endfunction

   function automatic mbox_result_type mk_result(status_type st, logic [7:0] b,
                                                 logic [6:0] l, logic last);
      mbox_result_type r;
      r.status      = st;
      r.out_byte    = b;
      r.out_length  = l;
      r.last_of_run = last;
      return r;
   endfunction

   // Compute the results of one accepted request and advance the mailbox mirror.
   task automatic predict_mailbox(input opcode_type op, input logic [3:0] obj,
                                  input logic [7:0] len, input logic [7:0] data);
      int bnk;
      int pos;
      int tag;
      int n;
      step_results.delete();
      if (op == OP_INSERT) begin
         // The first byte latches object and length and decides acceptance.
         if (ins_seen == 0) begin
            ins_obj      = obj;
            ins_len      = len;
            ins_rejected = 1'b0;
            if (int'(obj) >= NUM_OBJ || len == 0 || int'(len) > MAX_MSG ||
                int'(live_fill[obj]) + TAG_BYTES + int'(len) > BANK) begin
               ins_rejected = 1'b1;
            end else begin
               for (int i = 0; i < TAG_BYTES; i++)
                  store_bytes[store_addr(obj, live_bank[obj], live_fill[obj] + i)] =
                     (i == 0) ? len : 8'h00;
            end
         end
         if (!ins_rejected)
            store_bytes[store_addr(ins_obj, live_bank[ins_obj],
                                   live_fill[ins_obj] + TAG_BYTES + ins_seen)] = data;
         ins_seen = ins_seen + 8'd1;
         // Commit on the last byte.
         if (ins_len == 0 || ins_seen >= ins_len) begin
            if (!ins_rejected) begin
               live_fill[ins_obj]  = live_fill[ins_obj] + 13'(TAG_BYTES) + 13'(ins_len);
               live_count[ins_obj] = live_count[ins_obj] + 10'd1;
            end
            step_results.push_back(mk_result(ins_rejected ? ST_INS_REJ : ST_INS_OK,
                                              8'd0, 7'd0, 1'b1));
            ins_seen     = '0;
            ins_rejected = 1'b0;
         end
      end else begin
         // A get drops any partial insert.
         ins_seen     = '0;
         ins_rejected = 1'b0;
         if (int'(obj) >= NUM_OBJ) begin
            step_results.push_back(mk_result(ST_NO_MSG, 8'd0, 7'd0, 1'b1));
         end else begin
            if (drain_count[obj] == 0) begin
               drain_count[obj] = live_count[obj];
               drain_pos[obj]   = '0;
               live_count[obj]  = '0;
               live_fill[obj]   = '0;
               live_bank[obj]   = ~live_bank[obj];
            end
            if (drain_count[obj] == 0) begin
               step_results.push_back(mk_result(ST_NO_MSG, 8'd0, 7'd0, 1'b1));
            end else begin
               bnk = live_bank[obj] ? 0 : 1;
               pos = drain_pos[obj];
               tag = 0;
               for (int i = 0; i < TAG_BYTES; i++)
                  tag = tag | (int'(store_bytes[store_addr(obj, bnk, pos + i)]) << (8 * i));
               n = (tag > MAX_MSG) ? MAX_MSG : tag;
               if (n == 0) begin
                  step_results.push_back(mk_result(ST_NO_MSG, 8'd0, 7'd0, 1'b1));
               end else begin
                  for (int i = 0; i < n; i++)
                     step_results.push_back(mk_result(ST_MSG_BYTE,
                        store_bytes[store_addr(obj, bnk, pos + TAG_BYTES + i)],
                        7'(n), (i + 1 == n)));
                  drain_pos[obj]   = 13'((pos + TAG_BYTES + n) % BANK);
                  drain_count[obj] = drain_count[obj] - 10'd1;
               end
            end
         end
      end
   endtask

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 40)
         $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // Drive one request transaction from a falling edge, with random idle gaps first.
   task automatic send_item(input opcode_type op, input logic [3:0] obj,
                            input logic [7:0] len, input logic [7:0] data,
                            input logic fixed = 1'b0, input status_type fixed_status = ST_INS_OK);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_opcode         <= op;
      req_object_index   <= obj;
      req_message_length <= len;
      req_data_byte      <= data;
      do @(posedge clock); while (!req_ready);
      predict_mailbox(op, obj, len, data);
      if (fixed)
         results_due.push_back(mk_result(fixed_status, 8'd0, 7'd0, 1'b1));
      else
         foreach (step_results[i]) results_due.push_back(step_results[i]);
      items_sent++;
      @(negedge clock);
   endtask

   // A whole message; when scrambled, bytes after the first carry random object and length.
   task automatic send_message(input logic [3:0] obj, input int len, input bit scramble);
      int count;
      count = (len == 0) ? 1 : len;
      for (int k = 0; k < count; k++) begin
         if (scramble && k > 0)
            send_item(OP_INSERT, 4'($urandom_range(15)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
         else
            send_item(OP_INSERT, obj, 8'(len), 8'($urandom_range(255)));
      end
   endtask

   function automatic logic [3:0] pick_obj();
      return ($urandom_range(99) < 75) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
   endfunction

   function automatic int pick_len();
      int r;
      r = $urandom_range(99);
      if (r < 85) return $urandom_range(1, 6);
      if (r < 97) return $urandom_range(7, 63);
      return MAX_MSG;
   endfunction

   // One random operation: mostly well-formed messages and gets, some broken sequences.
   task automatic run_random_op();
      int r;
      int len;
      int k;
      r = $urandom_range(99);
      if (r < 55) begin
         send_message(pick_obj(), pick_len(), 1'b0);
      end else if (r < 85) begin
         send_item(OP_GET, pick_obj(), 8'($urandom_range(255)), 8'($urandom_range(255)));
      end else if (r < 91) begin
         send_message(pick_obj(), pick_len(), 1'b1);
      end else if (r < 96) begin
         len = $urandom_range(2, 20);
         k   = $urandom_range(1, len - 1);
         for (int i = 0; i < k; i++)
            send_item(OP_INSERT, 4'd1, 8'(len), 8'($urandom_range(255)));
         send_item(OP_GET, pick_obj(), 8'd0, 8'd0);
      end else begin
         len = ($urandom_range(3) == 0) ? $urandom_range(MAX_MSG + 1, 255) : 0;
         send_message(pick_obj(), len, 1'b0);
      end
   endtask

   // Hold the request side idle until every expected result has come back.
   task automatic wait_all_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (results_due.size() != 0);
   endtask

   // Receiver back-pressure.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Score every accepted result transaction against the oldest expectation.
   always @(posedge clock) begin
      mbox_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result status %0d byte %02h",
                                      rsp_status, rsp_out_byte));
         end else begin
            want = results_due.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
            if (rsp_out_byte !== want.out_byte)
               report_mismatch($sformatf("out_byte %02h, expected %02h",
                                         rsp_out_byte, want.out_byte));
            if (rsp_out_length !== want.out_length)
               report_mismatch($sformatf("out_length %0d, expected %0d",
                                         rsp_out_length, want.out_length));
            if (rsp_last_of_run !== want.last_of_run)
               report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                         rsp_last_of_run, want.last_of_run));
         end
      end
   end

   // Safety net against a hung handshake.
   initial begin
      #(TIMEOUT_CYCLES * (CLK_HIGH + CLK_LOW));
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int phase_start;
      int send_pct [4];
      int recv_pct [4];
      send_pct = '{0, 80, 0, 21};
      recv_pct = '{0, 0, 80, 21};

      for (int o = 0; o < NUM_OBJ; o++) begin
         live_bank[o]   = 1'b0;
         live_fill[o]   = '0;
         live_count[o]  = '0;
         drain_count[o] = '0;
         drain_pos[o]   = '0;
      end
      foreach (store_bytes[i]) store_bytes[i] = 8'h00;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table, no idling.
      for (int i = 0; i < N_DIRECTED; i++)
         send_item(directed_rows[i].op, directed_rows[i].obj, directed_rows[i].len,
                   directed_rows[i].data, directed_rows[i].fixed, directed_rows[i].fixed_status);
      wait_all_results();

      // Random traffic under each idling pattern, draining between patterns.
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_pct[p];
         recv_idle_pct = recv_pct[p];
         phase_start   = items_sent;
         while (items_sent - phase_start < RANDOM_ITEMS / 4)
            run_random_op();
         wait_all_results();
      end

      // Length just above the maximum, then the maximum itself.
      send_message(4'(LIMIT_OBJ), MAX_MSG + 1, 1'b0);
      send_message(4'(LIMIT_OBJ), MAX_MSG, 1'b0);
      send_item(OP_GET, 4'(LIMIT_OBJ), 8'd0, 8'd0);
      send_item(OP_GET, 4'(LIMIT_OBJ), 8'd0, 8'd0);

      req_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (results_due.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", results_due.size()));
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### files.f
design/ppmb_pkg.sv
design/ppmb_ram.sv
design/ppmb_ctrl.sv
design/ppmb_dp.sv
design/ping_pong_message_mailbox_top.sv
test/tb_ping_pong_message_mailbox_top.sv
